// ----- sv/rhh_pkg.sv -----
// Shared types, constants and codes for the Robin Hood hash table.
// No dependencies; used by every module of the block.
`default_nettype none

package rhh_pkg;

    localparam int SLOTS      = 1024;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int DIST_W     = IDX_W + 1;
    localparam int STEP_W     = IDX_W + 1;
    localparam int CNT_W      = IDX_W + 1;
    localparam int HASH_W     = 48;
    localparam int KEY_BITS   = 32;
    localparam int VAL_BITS   = 32;
    localparam int CMD_W      = 2;
    localparam int STAT_W     = 3;
    localparam int MAXE_W     = 11;
    localparam int POS_W      = 10;
    localparam int CMP_W      = (CNT_W > MAXE_W) ? CNT_W : MAXE_W;
    localparam logic [MAXE_W-1:0] MAX_RESET = MAXE_W'(768);
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = 1;
    localparam int QLVL_W     = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET    = 2'd0,
        CMD_GET    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_PROBE  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL      = 3'd5,
        ST_EMPTY     = 3'd6
    } t_status;

    typedef struct packed {
        logic [HASH_W-1:0]   hash;
        logic [KEY_BITS-1:0] key;
        logic [VAL_BITS-1:0] val;
        logic [DIST_W-1:0]   pdist;
    } t_slot;

    // Classified item as held in the queue between front and back.
    typedef struct packed {
        t_cmd                cmd;
        logic [HASH_W-1:0]   hash;
        logic [KEY_BITS-1:0] key;
        logic [VAL_BITS-1:0] val;
        logic [IDX_W-1:0]    start;
    } t_job;

endpackage

`default_nettype wire

// ----- sv/robin_hood_hash_table.sv -----
// Top level of the Robin Hood hash table: front queue and back sequencer.
// Depends on rhh_pkg, rhh_front and rhh_back.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+------------------------------------------
//   input    | i_in_valid / o_in_stall     | i_command i_key_hash i_key i_value i_slot_position
//   result   | o_out_valid / i_out_stall   | o_status o_out_key o_out_value o_entry_count
//   config   | i_cfg_we                    | i_cfg_wdata (max_entries)
//
// An item is registered in the front queue before the back takes it. There a walk
// takes the item, then reads and evaluates one slot at a time, and waits while the result
// is taken; delete also reads each follower and shifts it back into the hole, then clears
// the last hole. A set over the entry limit ends without a walk; a probe reads a single slot.
// After reset a clearing pass empties all 1024 slots; items queue meanwhile.
// Up to two items queue in front while a result waits on i_out_stall.
`default_nettype none

module robin_hood_hash_table (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [rhh_pkg::CMD_W-1:0]        i_command,
    input  wire  [rhh_pkg::HASH_W-1:0]       i_key_hash,
    input  wire  [rhh_pkg::KEY_BITS-1:0]     i_key,
    input  wire  [rhh_pkg::VAL_BITS-1:0]     i_value,
    input  wire  [rhh_pkg::POS_W-1:0]        i_slot_position,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [rhh_pkg::STAT_W-1:0]       o_status,
    output logic [rhh_pkg::KEY_BITS-1:0]     o_out_key,
    output logic [rhh_pkg::VAL_BITS-1:0]     o_out_value,
    output logic [rhh_pkg::MAXE_W-1:0]       o_entry_count,
    input  wire                              i_cfg_we,
    input  wire  [rhh_pkg::MAXE_W-1:0]       i_cfg_wdata
);

    logic            w_job_valid, w_job_pop;
    rhh_pkg::t_job   w_job;

    rhh_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_key_hash      (i_key_hash),
        .i_key           (i_key),
        .i_value         (i_value),
        .i_slot_position (i_slot_position),
        .o_job_valid     (w_job_valid),
        .o_job           (w_job),
        .i_job_pop       (w_job_pop)
    );

    rhh_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (w_job_valid),
        .i_job         (w_job),
        .o_job_pop     (w_job_pop),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_out_key     (o_out_key),
        .o_out_value   (o_out_value),
        .o_entry_count (o_entry_count)
    );

endmodule

`default_nettype wire

// ----- sv/rhh_front.sv -----
// Front end: accepts items, works out the start slot and queues them.
// Depends on rhh_pkg.
`default_nettype none

module rhh_front (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [rhh_pkg::CMD_W-1:0]        i_command,
    input  wire  [rhh_pkg::HASH_W-1:0]       i_key_hash,
    input  wire  [rhh_pkg::KEY_BITS-1:0]     i_key,
    input  wire  [rhh_pkg::VAL_BITS-1:0]     i_value,
    input  wire  [rhh_pkg::POS_W-1:0]        i_slot_position,
    output logic                             o_job_valid,
    output rhh_pkg::t_job                    o_job,
    input  wire                              i_job_pop
);

    rhh_pkg::t_job                   r_q [rhh_pkg::QDEPTH];
    logic [rhh_pkg::QPTR_W-1:0]      r_wp, r_rp;
    logic [rhh_pkg::QLVL_W-1:0]      r_lvl;
    rhh_pkg::t_job                   w_job;
    logic                            w_push, w_pop;

    always_comb begin
        w_job.cmd  = rhh_pkg::t_cmd'(i_command);
        w_job.hash = i_key_hash;
        w_job.key  = i_key;
        w_job.val  = i_value;
        // SLOTS is a power of two: the modulo is a mask
        if (w_job.cmd == rhh_pkg::CMD_PROBE) begin
            w_job.start = rhh_pkg::IDX_W'(i_slot_position);
        end else begin
            w_job.start = i_key_hash[rhh_pkg::IDX_W-1:0];
        end
    end

    assign o_in_stall  = (r_lvl == rhh_pkg::QLVL_W'(rhh_pkg::QDEPTH));
    assign o_job_valid = (r_lvl != '0);
    assign o_job       = r_q[r_rp];
    assign w_push      = i_in_valid && !o_in_stall;
    assign w_pop       = i_job_pop && o_job_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_lvl <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop)  r_rp <= r_rp + 1'b1;
            if (w_push && !w_pop) begin
                r_lvl <= r_lvl + 1'b1;
            end else if (w_pop && !w_push) begin
                r_lvl <= r_lvl - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/rhh_back.sv -----
// Back end: slot memory, probe walk sequencer, count, limit register
// and the result register. Depends on rhh_pkg.
`default_nettype none

module rhh_back (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_job_valid,
    input  rhh_pkg::t_job                    i_job,
    output logic                             o_job_pop,
    input  wire                              i_cfg_we,
    input  wire  [rhh_pkg::MAXE_W-1:0]       i_cfg_wdata,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [rhh_pkg::STAT_W-1:0]       o_status,
    output logic [rhh_pkg::KEY_BITS-1:0]     o_out_key,
    output logic [rhh_pkg::VAL_BITS-1:0]     o_out_value,
    output logic [rhh_pkg::MAXE_W-1:0]       o_entry_count
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_EVAL  = 7'b0001000,
        S_DRD   = 7'b0010000,
        S_DEV   = 7'b0100000,
        S_DCLR  = 7'b1000000
    } t_state;

    rhh_pkg::t_slot                  mem [rhh_pkg::SLOTS];
    rhh_pkg::t_slot                  r_rd;

    t_state                          r_state, n_state;
    rhh_pkg::t_cmd                   r_cmd, n_cmd;
    logic [rhh_pkg::KEY_BITS-1:0]    r_key, n_key;
    rhh_pkg::t_slot                  r_carry, n_carry;
    logic [rhh_pkg::IDX_W-1:0]       r_addr, n_addr;
    logic [rhh_pkg::IDX_W-1:0]       r_hole, n_hole;
    logic [rhh_pkg::STEP_W-1:0]      r_step, n_step;
    logic [rhh_pkg::CNT_W-1:0]       r_count, n_count;
    logic [rhh_pkg::MAXE_W-1:0]      r_max;
    logic                            r_ov, n_ov;
    rhh_pkg::t_status                r_ost, n_ost;
    logic [rhh_pkg::KEY_BITS-1:0]    r_okey, n_okey;
    logic [rhh_pkg::VAL_BITS-1:0]    r_oval, n_oval;

    logic                            w_we;
    logic [rhh_pkg::IDX_W-1:0]       w_waddr;
    rhh_pkg::t_slot                  w_wdata;
    logic                            w_full, w_match, w_last;
    logic [rhh_pkg::STEP_W-1:0]      w_step1;

    assign w_full  = (rhh_pkg::CMP_W'(r_count) >= rhh_pkg::CMP_W'(r_max))
                  || (r_count >= rhh_pkg::CNT_W'(rhh_pkg::SLOTS));
    assign w_match = (r_rd.hash == r_carry.hash) && (r_rd.key == r_carry.key);
    assign w_step1 = r_step + 1'b1;
    assign w_last  = (w_step1 == rhh_pkg::STEP_W'(rhh_pkg::SLOTS));

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_key   = r_key;
        n_carry = r_carry;
        n_addr  = r_addr;
        n_hole  = r_hole;
        n_step  = r_step;
        n_count = r_count;
        n_ov    = r_ov;
        n_ost   = r_ost;
        n_okey  = r_okey;
        n_oval  = r_oval;
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = r_carry;
        o_job_pop = 1'b0;

        if (r_ov && !i_out_stall) n_ov = 1'b0;

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = '0;
                n_addr  = r_addr + 1'b1;
                if (r_addr == rhh_pkg::IDX_W'(rhh_pkg::SLOTS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_job_valid && !r_ov) begin
                    o_job_pop     = 1'b1;
                    n_cmd         = i_job.cmd;
                    n_key         = i_job.key;
                    n_carry.hash  = i_job.hash;
                    n_carry.key   = i_job.key;
                    n_carry.val   = i_job.val;
                    n_carry.pdist = rhh_pkg::DIST_W'(1);
                    n_addr        = i_job.start;
                    n_step        = '0;
                    n_okey        = '0;
                    n_oval        = '0;
                    if (i_job.cmd == rhh_pkg::CMD_SET && w_full) begin
                        n_ov  = 1'b1;
                        n_ost = rhh_pkg::ST_FULL;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: n_state = S_EVAL;
            S_EVAL: begin
                n_state = S_READ;
                n_addr  = r_addr + 1'b1;
                n_step  = w_step1;
                case (r_cmd)
                    rhh_pkg::CMD_SET: begin
                        if (r_rd.pdist == '0) begin
                            w_we    = 1'b1;
                            n_count = r_count + 1'b1;
                            n_ost   = rhh_pkg::ST_INSERTED;
                            n_ov    = 1'b1;
                            n_state = S_IDLE;
                        end else if (w_match) begin
                            w_we        = 1'b1;
                            w_wdata     = r_rd;
                            w_wdata.val = r_carry.val;
                            n_okey  = r_key;
                            n_oval  = r_rd.val;
                            n_ost   = rhh_pkg::ST_REPLACED;
                            n_ov    = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            // richer resident gives its place to the carried entry
                            if (r_rd.pdist < r_carry.pdist) begin
                                w_we    = 1'b1;
                                n_carry = r_rd;
                            end
                            n_carry.pdist = n_carry.pdist + 1'b1;
                            if (w_last) begin
                                n_ost   = rhh_pkg::ST_FULL;
                                n_ov    = 1'b1;
                                n_state = S_IDLE;
                            end
                        end
                    end
                    rhh_pkg::CMD_PROBE: begin
                        n_state = S_IDLE;
                        n_ov    = 1'b1;
                        if (r_rd.pdist == '0) begin
                            n_ost = rhh_pkg::ST_EMPTY;
                        end else begin
                            n_ost  = rhh_pkg::ST_FOUND;
                            n_okey = r_rd.key;
                            n_oval = r_rd.val;
                        end
                    end
                    default: begin
                        // get and delete share the search walk
                        if (r_rd.pdist == '0 || (!w_match && w_last)) begin
                            n_ost   = rhh_pkg::ST_NOT_FOUND;
                            n_ov    = 1'b1;
                            n_state = S_IDLE;
                        end else if (w_match) begin
                            n_okey = r_rd.key;
                            n_oval = r_rd.val;
                            if (r_cmd == rhh_pkg::CMD_GET) begin
                                n_ost   = rhh_pkg::ST_FOUND;
                                n_ov    = 1'b1;
                                n_state = S_IDLE;
                            end else begin
                                n_hole  = r_addr;
                                n_step  = rhh_pkg::STEP_W'(1);
                                n_state = (rhh_pkg::SLOTS > 1) ? S_DRD : S_DCLR;
                            end
                        end
                    end
                endcase
            end
            S_DRD: n_state = S_DEV;
            S_DEV: begin
                if (r_rd.pdist <= rhh_pkg::DIST_W'(1)) begin
                    n_state = S_DCLR;
                end else begin
                    // shift the follower back into the hole
                    w_we          = 1'b1;
                    w_waddr       = r_hole;
                    w_wdata       = r_rd;
                    w_wdata.pdist = r_rd.pdist - 1'b1;
                    n_hole        = r_addr;
                    n_addr        = r_addr + 1'b1;
                    n_step        = w_step1;
                    n_state       = w_last ? S_DCLR : S_DRD;
                end
            end
            S_DCLR: begin
                w_we          = 1'b1;
                w_waddr       = r_hole;
                w_wdata       = r_rd;
                w_wdata.pdist = '0;
                if (r_count != '0) n_count = r_count - 1'b1;
                n_ost   = rhh_pkg::ST_REMOVED;
                n_ov    = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rd <= mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_carry <= n_carry;
        r_hole  <= n_hole;
        r_step  <= n_step;
        r_ost   <= n_ost;
        r_okey  <= n_okey;
        r_oval  <= n_oval;
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_max   <= rhh_pkg::MAX_RESET;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_count <= n_count;
            r_ov    <= n_ov;
            if (i_cfg_we) r_max <= i_cfg_wdata;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_status      = r_ost;
    assign o_out_key     = r_okey;
    assign o_out_value   = r_oval;
    assign o_entry_count = rhh_pkg::MAXE_W'(r_count);

endmodule

`default_nettype wire

// ----- bench/robin_hood_hash_table_tb.sv -----
// Self-checking bench for the Robin Hood hash table: random and directed commands
// against a behavioural table model. Depends on rhh_pkg and robin_hood_hash_table.
`timescale 1ns / 100ps

module robin_hood_hash_table_tb;

    typedef struct {
        logic [rhh_pkg::STAT_W-1:0]   status;
        logic [rhh_pkg::KEY_BITS-1:0] key;
        logic [rhh_pkg::VAL_BITS-1:0] val;
        logic [rhh_pkg::MAXE_W-1:0]   count;
    } t_answer;

    typedef struct {
        logic [rhh_pkg::HASH_W-1:0]   hash;
        logic [rhh_pkg::KEY_BITS-1:0] key;
        logic [rhh_pkg::VAL_BITS-1:0] val;
        int unsigned                  pdist;
    } t_entry;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic [rhh_pkg::CMD_W-1:0]       i_command = '0;
    logic [rhh_pkg::HASH_W-1:0]      i_key_hash = '0;
    logic [rhh_pkg::KEY_BITS-1:0]    i_key = '0;
    logic [rhh_pkg::VAL_BITS-1:0]    i_value = '0;
    logic [rhh_pkg::POS_W-1:0]       i_slot_position = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [rhh_pkg::STAT_W-1:0]      o_status;
    logic [rhh_pkg::KEY_BITS-1:0]    o_out_key;
    logic [rhh_pkg::VAL_BITS-1:0]    o_out_value;
    logic [rhh_pkg::MAXE_W-1:0]      o_entry_count;
    logic                            i_cfg_we = 1'b0;
    logic [rhh_pkg::MAXE_W-1:0]      i_cfg_wdata = '0;

    t_entry                          table_model [rhh_pkg::SLOTS];
    int unsigned                     entries;
    int unsigned                     entry_limit;
    t_answer                         pending_answers [$];
    bit                              failed = 0;
    longint unsigned                 cycles = 0;
    // keys kept in a small pool so that sets, gets and deletes hit each other
    logic [rhh_pkg::KEY_BITS-1:0]    pool_key [64];
    logic [rhh_pkg::HASH_W-1:0]      pool_hash [64];
    int unsigned                     key_span = 64;

    robin_hood_hash_table uut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3_000_000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int unsigned home_of(logic [rhh_pkg::HASH_W-1:0] h);
        return int'(h % rhh_pkg::SLOTS);
    endfunction

    function automatic bit locate(logic [rhh_pkg::HASH_W-1:0] h,
                                  logic [rhh_pkg::KEY_BITS-1:0] k,
                                  output int unsigned where);
        int unsigned i;
        i = home_of(h);
        where = 0;
        for (int n = 0; n < rhh_pkg::SLOTS; n++) begin
            if (table_model[i].pdist == 0) return 0;
            if (table_model[i].hash == h && table_model[i].key == k) begin
                where = i;
                return 1;
            end
            i = (i + 1) % rhh_pkg::SLOTS;
        end
        return 0;
    endfunction

    function automatic t_answer predict_command(rhh_pkg::t_cmd cmd,
            logic [rhh_pkg::HASH_W-1:0] h, logic [rhh_pkg::KEY_BITS-1:0] k,
            logic [rhh_pkg::VAL_BITS-1:0] v, logic [rhh_pkg::POS_W-1:0] pos);
        t_answer a;
        t_entry carry, tmp;
        int unsigned i, nx, where;
        bit done;
        a.status = rhh_pkg::ST_NOT_FOUND;
        a.key = '0;
        a.val = '0;
        case (cmd)
            rhh_pkg::CMD_SET: begin
                a.status = rhh_pkg::ST_FULL;
                if (entries < entry_limit && entries < rhh_pkg::SLOTS) begin
                    carry = '{h, k, v, 1};
                    i = home_of(h);
                    done = 0;
                    for (int n = 0; n < rhh_pkg::SLOTS && !done; n++) begin
                        if (table_model[i].pdist == 0) begin
                            table_model[i] = carry;
                            entries++;
                            a.status = rhh_pkg::ST_INSERTED;
                            done = 1;
                        end else if (table_model[i].hash == carry.hash &&
                                     table_model[i].key == carry.key) begin
                            a.status = rhh_pkg::ST_REPLACED;
                            a.key = k;
                            a.val = table_model[i].val;
                            table_model[i].val = carry.val;
                            done = 1;
                        end else begin
                            if (table_model[i].pdist < carry.pdist) begin
                                tmp = table_model[i];
                                table_model[i] = carry;
                                carry = tmp;
                            end
                            i = (i + 1) % rhh_pkg::SLOTS;
                            carry.pdist++;
                        end
                    end
                end
            end
            rhh_pkg::CMD_GET: begin
                if (locate(h, k, where)) begin
                    a.status = rhh_pkg::ST_FOUND;
                    a.key = table_model[where].key;
                    a.val = table_model[where].val;
                end
            end
            rhh_pkg::CMD_DELETE: begin
                if (locate(h, k, where)) begin
                    a.status = rhh_pkg::ST_REMOVED;
                    a.key = table_model[where].key;
                    a.val = table_model[where].val;
                    i = where;
                    table_model[i].pdist = 0;
                    // backward shift until a gap or an entry already at home
                    for (int n = 1; n < rhh_pkg::SLOTS; n++) begin
                        nx = (i + 1) % rhh_pkg::SLOTS;
                        if (table_model[nx].pdist <= 1) break;
                        table_model[i] = table_model[nx];
                        table_model[i].pdist--;
                        table_model[nx].pdist = 0;
                        i = nx;
                    end
                    if (entries > 0) entries--;
                end
            end
            default: begin
                i = pos % rhh_pkg::SLOTS;
                if (table_model[i].pdist == 0) begin
                    a.status = rhh_pkg::ST_EMPTY;
                end else begin
                    a.status = rhh_pkg::ST_FOUND;
                    a.key = table_model[i].key;
                    a.val = table_model[i].val;
                end
            end
        endcase
        a.count = rhh_pkg::MAXE_W'(entries);
        return a;
    endfunction

    function automatic int unsigned short_or_long_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // valid stays high between items sent back to back
    task automatic send_item(rhh_pkg::t_cmd cmd, logic [rhh_pkg::HASH_W-1:0] h,
                             logic [rhh_pkg::KEY_BITS-1:0] k,
                             logic [rhh_pkg::VAL_BITS-1:0] v,
                             logic [rhh_pkg::POS_W-1:0] pos, bit gaps);
        int unsigned gap;
        gap = gaps ? short_or_long_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_key_hash <= h;
        i_key <= k;
        i_value <= v;
        i_slot_position <= pos;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_answers.push_back(predict_command(cmd, h, k, v, pos));
    endtask

    // result side: random stall, check against the oldest expectation
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_answers.size() == 0) begin
                $display("%0t unexpected result: status exp none got %0d", $time, o_status);
                failed = 1;
            end else begin
                e = pending_answers.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t status exp %0d got %0d", $time, e.status, o_status);
                    failed = 1;
                end
                if (o_out_key !== e.key) begin
                    $display("%0t key exp %h got %h", $time, e.key, o_out_key);
                    failed = 1;
                end
                if (o_out_value !== e.val) begin
                    $display("%0t value exp %h got %h", $time, e.val, o_out_value);
                    failed = 1;
                end
                if (o_entry_count !== e.count) begin
                    $display("%0t count exp %0d got %0d", $time, e.count, o_entry_count);
                    failed = 1;
                end
            end
        end
        if ($urandom_range(0, 39) == 0) i_out_stall <= ~i_out_stall;
        else if (i_out_stall && $urandom_range(0, 2) == 0) i_out_stall <= 1'b0;
    end

    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_limit(int unsigned limit);
        drain_and_settle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= rhh_pkg::MAXE_W'(limit);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        entry_limit = limit & 11'h7FF;
    endtask

    task automatic new_pool(int unsigned span, bit clash);
        logic [rhh_pkg::HASH_W-1:0] base;
        base = rhh_pkg::HASH_W'({$urandom, $urandom});
        key_span = span;
        for (int i = 0; i < 64; i++) begin
            pool_key[i] = $urandom;
            // clashing pools share few home slots so chains grow long
            pool_hash[i] = clash
                ? base + rhh_pkg::HASH_W'(rhh_pkg::SLOTS * $urandom_range(0, 7) + (i % 4))
                : rhh_pkg::HASH_W'({$urandom, $urandom});
        end
    endtask

    task automatic test_directed();
        logic [rhh_pkg::HASH_W-1:0] top_hash;
        top_hash = 48'hFFFF_FFFF_FFFF;
        send_item(rhh_pkg::CMD_GET, 48'h0, 32'h0, 32'h0, 10'h0, 0);
        send_item(rhh_pkg::CMD_DELETE, top_hash, 32'hFFFF_FFFF, 32'h0, 10'h0, 0);
        send_item(rhh_pkg::CMD_PROBE, 48'h0, 32'h0, 32'h0, 10'h3FF, 0);
        send_item(rhh_pkg::CMD_SET, 48'h0, 32'h0, 32'h0, 10'h0, 0);
        send_item(rhh_pkg::CMD_SET, top_hash, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'h3FF, 0);
        send_item(rhh_pkg::CMD_SET, top_hash, 32'hFFFF_FFFF, 32'h1234_5678, 10'h0, 0);
        // same hash, different key: collides and wraps past the last slot
        send_item(rhh_pkg::CMD_SET, top_hash, 32'h0000_0001, 32'hAAAA_5555, 10'h0, 0);
        send_item(rhh_pkg::CMD_SET, 48'h3FF, 32'h0000_0002, 32'h5555_AAAA, 10'h0, 0);
        send_item(rhh_pkg::CMD_PROBE, 48'h0, 32'h0, 32'h0, 10'h3FF, 0);
        send_item(rhh_pkg::CMD_PROBE, 48'h0, 32'h0, 32'h0, 10'h001, 0);
        send_item(rhh_pkg::CMD_GET, top_hash, 32'h0000_0001, 32'h0, 10'h0, 0);
        send_item(rhh_pkg::CMD_GET, 48'h3FF, 32'h0000_0003, 32'h0, 10'h0, 0);
        send_item(rhh_pkg::CMD_DELETE, top_hash, 32'hFFFF_FFFF, 32'h0, 10'h0, 0);
        send_item(rhh_pkg::CMD_PROBE, 48'h0, 32'h0, 32'h0, 10'h3FF, 0);
        send_item(rhh_pkg::CMD_DELETE, 48'h0, 32'h0, 32'h0, 10'h0, 0);
        send_item(rhh_pkg::CMD_GET, 48'h3FF, 32'h0000_0002, 32'h0, 10'h0, 0);
    endtask

    task automatic test_full_limit();
        write_limit(0);
        send_item(rhh_pkg::CMD_SET, 48'h10, 32'h77, 32'h1, 10'h0, 0);
        write_limit(1);
        send_item(rhh_pkg::CMD_SET, 48'h11, 32'h78, 32'h2, 10'h0, 0);
        send_item(rhh_pkg::CMD_SET, 48'h12, 32'h79, 32'h3, 10'h0, 0);
        write_limit(3);
        send_item(rhh_pkg::CMD_SET, 48'h13, 32'h7A, 32'h4, 10'h0, 0);
        send_item(rhh_pkg::CMD_SET, 48'h11, 32'h78, 32'h5, 10'h0, 0);
    endtask

    task automatic random_burst(int unsigned items);
        int unsigned j, r;
        for (int n = 0; n < items; n++) begin
            j = $urandom_range(0, key_span - 1);
            r = $urandom_range(0, 99);
            if (r < 45)
                send_item(rhh_pkg::CMD_SET, pool_hash[j], pool_key[j], $urandom,
                          rhh_pkg::POS_W'($urandom), 1);
            else if (r < 65)
                send_item(rhh_pkg::CMD_GET, pool_hash[j], pool_key[j], $urandom,
                          rhh_pkg::POS_W'($urandom), 1);
            else if (r < 85)
                send_item(rhh_pkg::CMD_DELETE, pool_hash[j], pool_key[j], $urandom,
                          rhh_pkg::POS_W'($urandom), 1);
            else if (r < 93)
                send_item(rhh_pkg::CMD_PROBE, pool_hash[j], pool_key[j], $urandom,
                          rhh_pkg::POS_W'(pool_hash[j] + $urandom_range(0, 6)), 1);
            else
                send_item(rhh_pkg::t_cmd'($urandom_range(0, 3)),
                          rhh_pkg::HASH_W'({$urandom, $urandom}), $urandom,
                          $urandom, rhh_pkg::POS_W'($urandom), 1);
        end
    endtask

    task automatic test_random_spread();
        write_limit(768);
        new_pool(64, 0);
        random_burst(500);
    endtask

    task automatic test_random_clusters();
        write_limit(1024);
        new_pool(64, 1);
        random_burst(600);
        write_limit(2047);
        new_pool(48, 1);
        random_burst(300);
    endtask

    task automatic test_small_limit();
        write_limit(20);
        new_pool(40, 1);
        random_burst(300);
    endtask

    initial begin
        for (int i = 0; i < rhh_pkg::SLOTS; i++) table_model[i] = '{'0, '0, '0, 0};
        entries = 0;
        entry_limit = 768;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_limit();
        test_random_spread();
        test_random_clusters();
        test_small_limit();
        drain_and_settle();
        if (!failed) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
